// ----- hdl/ttceb_pkg.sv -----
// Shared constants, types and the quarter-wave cosine table for the emergency brake block.
package ttceb_pkg;

	localparam int unsigned COS_DEPTH = 256;
	localparam int unsigned COS_IDX_W = $clog2(COS_DEPTH);
	localparam int unsigned COS_W     = 15;
	localparam int unsigned ANGLE_W   = 16;
	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned RANGE_W   = 16;
	localparam int unsigned THR_W     = 16;
	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned CLOSE_W   = 17;
	localparam int unsigned PROD_W    = 33;
	localparam int unsigned STEP_W    = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ANGLE_W-1:0] ANGLE_START_RST = 16'd40960;
	localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 16'd45;
	localparam logic [THR_W-1:0]   THR_RST         = 16'd102;
	localparam logic [COUNT_W-1:0] LIMIT_RST       = 11'd102;
	localparam logic [RANGE_W-1:0] NO_RETURN       = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX       = 11'h7FF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_START = 2'd0,
		REG_ANGLE_STEP  = 2'd1,
		REG_TTC_THR     = 2'd2,
		REG_HIT_LIMIT   = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL1  = 5'b00010,
		ST_SCALE = 5'b00100,
		ST_MUL2  = 5'b01000,
		ST_CMP   = 5'b10000
	} state_t;

	typedef logic [COS_W-1:0] cos_tab_t [COS_DEPTH];

	// cos(pi/2 * k / depth): Taylor series in Q30, rounded to Q14
	function automatic logic [COS_W-1:0] cos_entry(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        rnd;
		x    = (64'd1686629713 * 64'(k)) / 64'(COS_DEPTH);
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		acc  = signed'(term);
		for (int n = 1; n <= 12; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * n - 1) * (2 * n));
			if ((n % 2) == 1)
				acc = acc - signed'(term);
			else
				acc = acc + signed'(term);
		end
		if (acc < 0)
			acc = 0;
		rnd = (unsigned'(acc) + (64'd1 << 15)) >> 16;
		return rnd[COS_W-1:0];
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		for (int k = 0; k < COS_DEPTH; k++)
			t[k] = cos_entry(k);
		return t;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

	// table entry j, zero past the end of the quarter wave
	function automatic logic [COS_W-1:0] quarter(input logic [COS_IDX_W:0] j);
		logic [COS_W-1:0] v;
		if (j[COS_IDX_W])
			v = '0;
		else
			v = COS_TAB[j[COS_IDX_W-1:0]];
		return v;
	endfunction

endpackage

// ----- hdl/ttc_emergency_brake.sv -----
// Time-to-collision emergency brake: per-beam hit test with serial multiplier and scan result.
//
// A speed update (tuser 0) is taken without leaving idle. A lidar beam (tuser 1) holds off
// the next request until its steps are done: one 2-bit-per-cycle shift-add multiplier forms
// speed * cos(angle) in 8 steps, a scale step turns it into a closing speed in mm/s, the same
// multiplier forms threshold * closing speed in 8 more steps, and a compare step compares and
// updates the hit count. On a beam marked tlast a result {hits, brake} is placed in the
// output register; if an earlier result is still waiting there, the block holds in the
// compare step until it is taken. Configuration writes are taken only while the block is
// idle and no request is offered.
module ttc_emergency_brake (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // speed_value [15:0], range_mm [31:16]
	input  logic        s_tuser,   // req_type
	input  logic        s_tlast,   // last_beam
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // brake [0], hits [11:1], zero [15:12]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ttceb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import ttceb_pkg::*;

	state_t state_q;

	logic [ANGLE_W-1:0] angle_start_q;
	logic [ANGLE_W-1:0] angle_step_q;
	logic [THR_W-1:0]   thr_q;
	logic [COUNT_W-1:0] limit_q;

	logic signed [SPEED_W-1:0] speed_q;
	logic [ANGLE_W-1:0]        angle_q;
	logic [COUNT_W-1:0]        count_q;
	logic [RANGE_W-1:0]        range_q;
	logic                      last_q;
	logic                      pos_q;

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [THR_W-1:0]  mult_q;
	logic [STEP_W-1:0] step_q;

	logic               out_valid_q;
	logic               brake_q;
	logic [COUNT_W-1:0] hits_q;

	logic [1:0]           quad;
	logic [COS_IDX_W-1:0] idx;
	logic [COS_IDX_W:0]   mirror;
	logic [COS_W-1:0]     cos_mag;
	logic                 cos_neg;
	logic                 speed_neg;
	logic [SPEED_W-1:0]   speed_mag;
	logic [PROD_W-1:0]    partial;
	logic [39:0]          scaled;
	logic [CLOSE_W-1:0]   closing;
	logic                 hit;
	logic [COUNT_W-1:0]   count_next;
	logic                 accept;
	logic                 out_free;
	logic                 emit;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !s_tvalid;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {4'b0, hits_q, brake_q};
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign emit      = (state_q == ST_CMP) && last_q && out_free;

	// cosine of the current beam angle as sign and magnitude
	assign quad   = angle_q[ANGLE_W-1 -: 2];
	assign idx    = angle_q[ANGLE_W-3 -: COS_IDX_W];
	assign mirror = (COS_IDX_W+1)'(COS_DEPTH) - {1'b0, idx};

	always_comb begin
		case (quad)
			2'd0: begin
				cos_mag = quarter({1'b0, idx});
				cos_neg = 1'b0;
			end
			2'd1: begin
				cos_mag = quarter(mirror);
				cos_neg = 1'b1;
			end
			2'd2: begin
				cos_mag = quarter({1'b0, idx});
				cos_neg = 1'b1;
			end
			default: begin
				cos_mag = quarter(mirror);
				cos_neg = 1'b0;
			end
		endcase
	end

	assign speed_neg = speed_q[SPEED_W-1];
	assign speed_mag = speed_neg ? SPEED_W'(-speed_q) : SPEED_W'(speed_q);

	// one radix-4 digit of the shared multiplier
	assign partial = (mult_q[0] ? mcand_q : '0) + (mult_q[1] ? {mcand_q[PROD_W-2:0], 1'b0} : '0);

	// closing speed in mm/s: (P * 1000) >> 22
	assign scaled  = {acc_q[29:0], 10'b0} - {6'b0, acc_q[29:0], 4'b0} - {7'b0, acc_q[29:0], 3'b0};
	assign closing = scaled[22 +: CLOSE_W];

	assign hit = (range_q == '0) ||
		((range_q != NO_RETURN) && (PROD_W'({range_q, 8'b0}) < acc_q));
	assign count_next = (hit && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			angle_start_q <= ANGLE_START_RST;
			angle_step_q  <= ANGLE_STEP_RST;
			thr_q         <= THR_RST;
			limit_q       <= LIMIT_RST;
			speed_q       <= '0;
			angle_q       <= ANGLE_START_RST;
			count_q       <= '0;
			range_q       <= '0;
			last_q        <= 1'b0;
			pos_q         <= 1'b0;
			acc_q         <= '0;
			mcand_q       <= '0;
			mult_q        <= '0;
			brake_q       <= 1'b0;
			hits_q        <= '0;
			out_valid_q   <= 1'b0;
			step_q        <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!s_tuser) begin
							speed_q <= signed'(s_tdata[15:0]);
						end else begin
							range_q <= s_tdata[31:16];
							last_q  <= s_tlast;
							pos_q   <= (speed_q != '0) && (cos_mag != '0) &&
								(speed_neg == cos_neg);
							mcand_q <= PROD_W'(speed_mag);
							mult_q  <= THR_W'(cos_mag);
							acc_q   <= '0;
							step_q  <= '0;
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1, ST_MUL2: begin
					acc_q   <= acc_q + partial;
					mcand_q <= {mcand_q[PROD_W-3:0], 2'b0};
					mult_q  <= {2'b0, mult_q[THR_W-1:2]};
					step_q  <= step_q + 1'b1;
					if (step_q == '1)
						state_q <= (state_q == ST_MUL1) ? ST_SCALE : ST_CMP;
				end
				ST_SCALE: begin
					mcand_q <= pos_q ? PROD_W'(closing) : '0;
					mult_q  <= thr_q;
					acc_q   <= '0;
					step_q  <= '0;
					state_q <= ST_MUL2;
				end
				ST_CMP: begin
					if (!last_q) begin
						count_q <= count_next;
						angle_q <= angle_q + angle_step_q;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						brake_q     <= count_next > limit_q;
						hits_q      <= count_next;
						count_q     <= '0;
						angle_q     <= angle_start_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_ANGLE_START: begin
						angle_start_q <= cfg_data;
						angle_q       <= cfg_data;
					end
					REG_ANGLE_STEP: angle_step_q <= cfg_data;
					REG_TTC_THR:    thr_q        <= cfg_data;
					REG_HIT_LIMIT:  limit_q      <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	a_beam_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser |=> state_q == ST_MUL1)
		else $error("beam request did not start the multiplier");

	a_result_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_CMP) && $past(last_q))
		else $error("result appeared outside the compare step of a last beam");

	a_closing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE && !pos_q |=> mcand_q == '0)
		else $error("non-positive closing product gave a nonzero closing speed");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> count_q == '0)
		else $error("hit count not cleared after scan result");

endmodule

// ----- bench/ttc_emergency_brake_tb.sv -----
// Self-checking stream testbench for the time-to-collision emergency brake block.
module ttc_emergency_brake_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ttceb_pkg::*;

	localparam logic REQ_SPEED = 1'b0;
	localparam logic REQ_BEAM  = 1'b1;

	typedef struct {
		logic        kind;
		logic [15:0] speed;
		logic [15:0] rng;
		logic        last;
	} brake_req_t;

	typedef struct {
		logic        brake;
		logic [10:0] hits;
	} scan_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;   // speed_value [15:0], range_mm [31:16]
	logic                 s_tuser;   // req_type
	logic                 s_tlast;   // last_beam
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // brake [0], hits [11:1], zero [15:12]
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	ttc_emergency_brake DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	brake_req_t   beam_feed[$];
	scan_report_t scan_reports[$];
	int unsigned  cos_rom [COS_DEPTH];

	// mirror of the block's registers and scan state
	logic signed [15:0] speed_now;
	logic [15:0]        angle_now;
	logic [10:0]        count_now;
	logic [15:0]        start_r;
	logic [15:0]        step_r;
	logic [15:0]        thr_r;
	logic [10:0]        limit_r;

	int          mismatches;
	logic        req_taken;
	int unsigned gap_left;
	int unsigned burst_left;
	int unsigned bursts;
	logic        drain_wait;
	logic        steady;
	logic [12:0] stall_seed;
	int          stall_pos;

	always #2 clk = ~clk;

	function automatic logic [14:0] taylor_cos(int unsigned k);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned t;
		longint          sum;
		ang    = (64'd1686629713 * 64'(k)) / 64'(COS_DEPTH);
		ang_sq = (ang * ang) >> 30;
		t      = 64'd1 << 30;
		sum    = signed'(t);
		for (int n = 1; n <= 12; n++) begin
			t = (t * ang_sq) >> 30;
			t = t / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1)
				sum = sum - signed'(t);
			else
				sum = sum + signed'(t);
		end
		if (sum < 0)
			sum = 0;
		return 15'((unsigned'(sum) + 64'd32768) >> 16);
	endfunction

	function automatic int cos_of(logic [15:0] a);
		logic [COS_IDX_W-1:0] idx;
		int                   fwd;
		int                   back;
		int                   c;
		idx  = a[13 -: COS_IDX_W];
		fwd  = cos_rom[idx];
		back = (idx == 0) ? 0 : cos_rom[COS_DEPTH - idx];
		case (a[15:14])
			2'd0: c = fwd;
			2'd1: c = -back;
			2'd2: c = -fwd;
			default: c = back;
		endcase
		return c;
	endfunction

	task automatic scan_step(logic kind, logic [31:0] data, logic lst);
		longint          prod;
		longint unsigned closing;
		logic [15:0]     rng_v;
		logic            hit;
		scan_report_t    r;
		if (kind == REQ_SPEED) begin
			speed_now = data[15:0];
		end else begin
			rng_v   = data[31:16];
			prod    = longint'(speed_now) * longint'(cos_of(angle_now));
			closing = (prod > 0) ? (unsigned'(prod) * 64'd1000) >> 22 : 64'd0;
			if (rng_v == 16'd0)
				hit = 1'b1;
			else if (rng_v == NO_RETURN)
				hit = 1'b0;
			else
				hit = (64'(rng_v) << 8) < 64'(thr_r) * closing;
			if (hit && count_now != COUNT_MAX)
				count_now = count_now + 1'b1;
			angle_now = angle_now + step_r;
			if (lst) begin
				r.brake = count_now > limit_r;
				r.hits  = count_now;
				scan_reports.insert(scan_reports.size(), r);
				count_now = '0;
				angle_now = start_r;
			end
		end
	endtask

	task automatic push_req(logic kind, logic [15:0] spd, logic [15:0] rng, logic lst);
		brake_req_t q;
		q.kind  = kind;
		q.speed = spd;
		q.rng   = rng;
		q.last  = lst;
		beam_feed.insert(beam_feed.size(), q);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ANGLE_START: begin
				start_r   = val;
				angle_now = val;
			end
			REG_ANGLE_STEP: step_r = val;
			REG_TTC_THR:    thr_r = val;
			default:        limit_r = val[10:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (beam_feed.size() != 0 || s_tvalid || scan_reports.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	function automatic logic [15:0] reg_value(cfg_reg_t r);
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0: v = 16'h0000;
			1: v = 16'hFFFF;
			default: begin
				case (r)
					REG_TTC_THR:   v = 16'($urandom_range(0, 1024));
					REG_HIT_LIMIT: v = 16'($urandom_range(0, 40));
					default:       v = 16'($urandom);
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_speed();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: v = {{4{v[11]}}, v[11:0]};
			2: v = v[0] ? 16'h7FFF : 16'h8000;
			default: v[15:14] = 2'b00;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_range();
		logic [15:0] v;
		case ($urandom_range(0, 11))
			0: v = 16'h0000;
			1: v = NO_RETURN;
			default: v = 16'($urandom_range(1, (1 << $urandom_range(1, 16)) - 1));
		endcase
		return v;
	endfunction

	task automatic fill_traffic(int n);
		int left;
		int len;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 6) == 0) begin
				push_req(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
				left--;
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					push_req(REQ_SPEED, pick_speed(), 16'($urandom), 1'($urandom));
					left--;
				end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
					: $urandom_range(1, 30);
				for (int b = 0; b < len; b++)
					push_req(REQ_BEAM, 16'($urandom), pick_range(), b == len - 1);
				left -= len;
			end
		end
	endtask

	// sender: bursts with gaps, holds a request until it is taken
	always @(negedge clk) begin : feed
		brake_req_t nxt;
		logic       go;
		go = 1'b0;
		if (s_tvalid && !req_taken) begin
			go = 1'b1;
		end else if (!arst_n) begin
			go = 1'b0;
		end else if (gap_left != 0) begin
			gap_left--;
		end else if (drain_wait) begin
			drain_wait = (scan_reports.size() != 0);
		end else if (beam_feed.size() != 0) begin
			nxt = beam_feed.pop_front();
			s_tuser <= nxt.kind;
			s_tdata <= {nxt.rng, nxt.speed};
			s_tlast <= nxt.last;
			go = 1'b1;
			if (burst_left != 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 23);
				case ($urandom_range(0, 3))
					0: gap_left = 0;
					1, 2: gap_left = $urandom_range(1, 4);
					default: gap_left = $urandom_range(5, 12);
				endcase
				if (steady)
					gap_left = 0;
				bursts++;
				if (bursts == 3 || $urandom_range(0, 31) == 0)
					drain_wait = 1'b1;
			end
		end
		s_tvalid <= go;
	end

	always @(negedge clk) begin
		m_tready  <= stall_seed[stall_pos];
		stall_pos <= (stall_pos == 12) ? 0 : stall_pos + 1;
	end

	always @(posedge clk) begin : observe
		scan_report_t want;
		req_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			scan_step(s_tuser, s_tdata, s_tlast);
		if (m_tvalid && m_tready) begin
			if (scan_reports.size() == 0) begin
				$display("%0t: unexpected scan report, tdata %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = scan_reports.pop_front();
				if (m_tdata[0] !== want.brake) begin
					$display("%0t: brake expected %0b actual %0b", $time, want.brake,
						m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[11:1] !== want.hits) begin
					$display("%0t: hits expected %0d actual %0d", $time, want.hits,
						m_tdata[11:1]);
					mismatches++;
				end
				if (m_tdata[15:12] !== 4'h0) begin
					$display("%0t: pad bits expected 0 actual %h", $time, m_tdata[15:12]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("ttc_emergency_brake_tb NOT OK");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		mismatches = 0;
		req_taken  = 1'b0;
		gap_left   = 0;
		burst_left = 0;
		bursts     = 0;
		drain_wait = 1'b0;
		steady     = 1'b0;
		stall_seed = 13'h1FFF;
		stall_pos  = 0;
		for (int k = 0; k < COS_DEPTH; k++)
			cos_rom[k] = taylor_cos(k);
		speed_now = '0;
		start_r   = ANGLE_START_RST;
		step_r    = ANGLE_STEP_RST;
		thr_r     = THR_RST;
		limit_r   = LIMIT_RST;
		angle_now = ANGLE_START_RST;
		count_now = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero speed, ignored tlast on speed, no return, edge ranges
		push_req(REQ_BEAM,  16'h1234, 16'h0000, 1'b1);
		push_req(REQ_SPEED, 16'h8000, 16'hFFFF, 1'b1);
		push_req(REQ_BEAM,  16'hFFFF, NO_RETURN, 1'b0);
		push_req(REQ_BEAM,  16'h0000, 16'h0001, 1'b0);
		push_req(REQ_BEAM,  16'hAAAA, 16'hFFFE, 1'b0);
		push_req(REQ_BEAM,  16'h5555, 16'h0064, 1'b1);
		push_req(REQ_SPEED, 16'h7FFF, 16'h0000, 1'b0);
		push_req(REQ_BEAM,  16'h0000, 16'h0001, 1'b1);
		wait_idle();

		// quarter-turn steps walk every quadrant and wrap back to zero
		write_reg(REG_ANGLE_START, 16'h0000);
		write_reg(REG_ANGLE_STEP, 16'h4000);
		write_reg(REG_TTC_THR, 16'hFFFF);
		write_reg(REG_HIT_LIMIT, 16'h0000);
		for (int b = 0; b < 5; b++)
			push_req(REQ_BEAM, 16'hFFFF, 16'h0001, b == 4);
		wait_idle();

		// zero threshold: only zero range hits; limit masked to 11 bits
		write_reg(REG_TTC_THR, 16'h0000);
		write_reg(REG_ANGLE_START, 16'hFFFF);
		write_reg(REG_ANGLE_STEP, 16'hFFFF);
		write_reg(REG_HIT_LIMIT, 16'hFFFF);
		push_req(REQ_SPEED, 16'h7FFF, 16'h0000, 1'b0);
		push_req(REQ_BEAM,  16'h0000, 16'h0000, 1'b0);
		push_req(REQ_BEAM,  16'hFFFF, 16'h0001, 1'b0);
		push_req(REQ_BEAM,  16'h0000, NO_RETURN, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 4; i++)
				if ($urandom_range(0, 3) != 0 || ph == 0)
					write_reg(cfg_reg_t'(i), reg_value(cfg_reg_t'(i)));
			steady     = ($urandom_range(0, 3) == 0);
			stall_seed = ($urandom_range(0, 3) == 0) ? 13'h1FFF : (13'($urandom) | 13'h1);
			fill_traffic(240);
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("ttc_emergency_brake_tb OK");
		else
			$display("ttc_emergency_brake_tb NOT OK");
		$finish;
	end

endmodule

// ----- ttc_emergency_brake.f -----
hdl/ttceb_pkg.sv
hdl/ttc_emergency_brake.sv
bench/ttc_emergency_brake_tb.sv
